FILE: rtl/core/lbp_pkg.sv
// Shared constants, types and functions of the 3x3 local binary pattern block.
`default_nettype none
package lbp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W   = 8;
	localparam int DIM_W   = 11;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int CODE_W  = 8;
	localparam int CRD_W   = 10;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] DIM_MIN          = 11'd3;
	localparam logic [DIM_W-1:0] WIDTH_MAX_DIM    = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX_DIM   = DIM_W'(MAX_HEIGHT);
	localparam logic [DIM_W-1:0] WIDTH_RESET      = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET     = 11'd480;

	// Position of one pixel in the frame plus its end-of-row/frame flags.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last_col;
		logic             last_row;
	} pos_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v < DIM_MIN) begin
			r = DIM_MIN;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Bit 0 is top-left, then clockwise round to bit 7 on the left.
	function automatic logic [CODE_W-1:0] lbp_code(
			input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] t,
			input logic [PIX_W-1:0] tr, input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] br, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] l,
			input logic [PIX_W-1:0] c);
		logic [CODE_W-1:0] code;
		code[0] = (tl >= c);
		code[1] = (t  >= c);
		code[2] = (tr >= c);
		code[3] = (r  >= c);
		code[4] = (br >= c);
		code[5] = (b  >= c);
		code[6] = (bl >= c);
		code[7] = (l  >= c);
		return code;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lbp_pos_ctrl.sv
// Frame size registers and the raster position counters.
`default_nettype none
module lbp_pos_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lbp_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic                          step,
	output lbp_pkg::pos_t                      cur
);
	import lbp_pkg::*;

	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;
	logic             restart;

	assign width_eff  = clamp_dim(frame_width_q, WIDTH_MAX_DIM);
	assign height_eff = clamp_dim(frame_height_q, HEIGHT_MAX_DIM);
	assign restart    = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
		cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		cur.row      = row_q;
		cur.col      = col_q;
		cur.last_col = (DIM_W'(col_q) + 11'd1) >= width_eff;
		cur.last_row = (DIM_W'(row_q) + 11'd1) >= height_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
			row_q          <= '0;
			col_q          <= '0;
		end else if (restart) begin
			// A write to the width or height register starts a fresh frame.
			if (cfg_index == REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end else begin
				frame_height_q <= cfg_data;
			end
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			if (cur.last_col) begin
				col_q <= '0;
				row_q <= cur.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/lbp_line_store.sv
// The two row stores, each with one write port and one registered read port.
`default_nettype none
module lbp_line_store (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [lbp_pkg::COL_W-1:0] rd_addr,
	input  wire logic                      wr_en,
	input  wire logic [lbp_pkg::COL_W-1:0] wr_addr,
	input  wire logic [lbp_pkg::PIX_W-1:0] wr_older,
	input  wire logic [lbp_pkg::PIX_W-1:0] wr_newer,
	output logic      [lbp_pkg::PIX_W-1:0] top_q,
	output logic      [lbp_pkg::PIX_W-1:0] mid_q
);
	import lbp_pkg::*;

	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_older;
			newer_mem[wr_addr] <= wr_newer;
		end
	end

	// Read data holds while the reader is stalled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_q <= older_mem[rd_addr];
			mid_q <= newer_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/lbp_window.sv
// Two trailing window columns and the combinational pattern code.
`default_nettype none
module lbp_window (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift,
	input  wire logic [lbp_pkg::PIX_W-1:0]  top,
	input  wire logic [lbp_pkg::PIX_W-1:0]  mid,
	input  wire logic [lbp_pkg::PIX_W-1:0]  bot,
	output logic      [lbp_pkg::CODE_W-1:0] code
);
	import lbp_pkg::*;

	// Entries 0..2: column c-2 top/mid/bottom; 3..5: column c-1.
	logic [PIX_W-1:0] win_q [6];

	assign code = lbp_code(win_q[0], win_q[3], top, mid, bot, win_q[5],
		win_q[2], win_q[1], win_q[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/local_binary_pattern_3x3_top.sv
// Top level of the streaming 3x3 local binary pattern block.
//
//   channel   direction   handshake            payload
//   s_*       in          s_tvalid / s_tready  s_tdata: pixel
//   m_*       out         m_tvalid / m_tready  m_tdata: code, row, col; m_tlast: frame end
//   cfg_*     in          cfg_we               cfg_index, cfg_data
//
// One word is taken per clock while m_tready does not stall the output. A
// result moves from stage 1 into the output register; the rate is set by the
// single read port of the line stores, read and written once per pixel.
// Reset clears the control state, the frame counters and the window; the line
// stores have no reset and need no clearing pass.
// A stall on m_tready holds the output word and the stage-1 pixel; the input
// keeps accepting until stage 1 is also occupied.
`default_nettype none
module local_binary_pattern_3x3_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input pixel stream.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lbp_pkg::PIX_W-1:0]     s_tdata,      // [7:0] pixel
	// Result stream.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [lbp_pkg::OUT_DATA_W-1:0]     m_tdata,      // [7:0] pattern_code,
	                                                         // [17:8] centre_row,
	                                                         // [27:18] centre_col,
	                                                         // [31:28] zero
	output logic                               m_tlast,      // frame_end
	// Configuration writes.
	input  wire logic                          cfg_we,
	input  wire logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lbp_pkg::DIM_W-1:0]     cfg_data
);
	import lbp_pkg::*;

	pos_t             cur_pos;
	logic             accept;
	logic             advance;
	logic             emit;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	pos_t             pos_s1;
	logic [PIX_W-1:0] top_rd;
	logic [PIX_W-1:0] mid_rd;
	logic [CODE_W-1:0] code;
	logic [CRD_W-1:0] crow;
	logic [CRD_W-1:0] ccol;

	// Stage 1 holds the accepted pixel while the line stores deliver its
	// column; it drains whenever the output register is free or being taken.
	assign accept   = s_tvalid && s_tready;
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Only interior centres produce a word; the centre sits one row up and
	// one column left of the pixel in stage 1.
	assign emit = (pos_s1.row >= ROW_W'(2)) && (pos_s1.col >= COL_W'(2));
	assign crow = CRD_W'(pos_s1.row - 1'b1);
	assign ccol = CRD_W'(pos_s1.col - 1'b1);

	lbp_pos_ctrl u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.cur       (cur_pos)
	);

	// The next pixel reads column c+1 (or 0) while the pixel in stage 1
	// writes column c; they meet at one address only if a register write holds column 0.
	lbp_line_store u_store (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (cur_pos.col),
		.wr_en    (advance),
		.wr_addr  (pos_s1.col),
		.wr_older (mid_rd),
		.wr_newer (pixel_s1),
		.top_q    (top_rd),
		.mid_q    (mid_rd)
	);

	lbp_window u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (advance),
		.top    (top_rd),
		.mid    (mid_rd),
		.bot    (pixel_s1),
		.code   (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= s_tdata;
			pos_s1   <= cur_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= emit;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {{(OUT_DATA_W - CODE_W - 2 * CRD_W){1'b0}}, ccol, crow, code};
			m_tlast <= pos_s1.last_row && pos_s1.last_col;
		end
	end

`ifndef NO_ASSERTIONS
	// Every emitted word names an interior centre.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:8] != '0) && (m_tdata[27:18] != '0))
		else $error("result names a border pixel");

	// A pixel that cannot drain stays put in stage 1.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pixel_s1) && $stable(pos_s1))
		else $error("stage 1 lost its pixel during a stall");

	// A write to the width or height register restarts the frame at the origin.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)
		|=> cur_pos.row == '0 && cur_pos.col == '0)
		else $error("configuration write did not restart the frame");

	// An input is never taken while stage 1 is full and blocked.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !valid_s1 || advance)
		else $error("pixel accepted over a stalled stage 1");
`endif

endmodule
`default_nettype wire
